>>> hdl/dq_pkg.sv
// dq_pkg: command codes, error codes, fixed port widths and shared types
// for the double-ended queue; no dependencies
package dq_pkg;

    // fixed widths of the command and result fields
    localparam int CMD_W       = 3;
    localparam int OUT_VALUE_W = 32;
    localparam int OUT_COUNT_W = 9;
    localparam int ERR_W       = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_POP_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_PUSH_FULL = 2'd2;

    // command strobe from the sequencer to the pointer unit
    typedef struct packed {
        logic             step;
        logic [CMD_W-1:0] cmd;
    } ptr_ctrl_t;

    // status returned by the pointer unit
    typedef struct packed {
        logic [ERR_W-1:0] err;
        logic             is_empty;
    } ptr_status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DONE = 3'b100
    } seq_state_t;

endpackage

>>> hdl/dq_ram.sv
// dq_ram: generic single-write, single-read synchronous RAM with registered read
// no dependencies
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/dq_ptr.sv
// dq_ptr: ring pointer unit: front index, occupancy, error code and ram addresses
// depends on dq_pkg
module dq_ptr #(
    parameter int CAPACITY = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dq_pkg::ptr_ctrl_t             ctrl,
    output logic                          wr_en,
    output logic [$clog2(CAPACITY)-1:0]   wr_addr,
    output logic [$clog2(CAPACITY)-1:0]   front_addr,
    output logic [$clog2(CAPACITY)-1:0]   back_addr,
    output logic [$clog2(CAPACITY+1)-1:0] occupancy,
    output dq_pkg::ptr_status_t           status
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = IDX_W + 1;

    logic [IDX_W-1:0]         front_reg, front_next;
    logic [CNT_W-1:0]         occ_reg, occ_next;
    logic [dq_pkg::ERR_W-1:0] err_reg, err_next;

    logic             full, empty;
    logic [IDX_W-1:0] front_dec, front_inc, tail_addr;
    logic [SUM_W-1:0] tail_sum, last_sum;

    assign full  = (occ_reg == CNT_W'(CAPACITY));
    assign empty = (occ_reg == '0);

    // neighbors of the front position, wrapping at the ring ends
    assign front_dec = (front_reg == '0) ? IDX_W'(CAPACITY - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IDX_W'(CAPACITY - 1)) ? '0 : front_reg + 1'b1;

    // slot after the back and the back itself, reduced modulo the capacity
    assign tail_sum  = {1'b0, front_reg} + SUM_W'(occ_reg);
    assign last_sum  = tail_sum - 1'b1;
    assign tail_addr = (tail_sum >= SUM_W'(CAPACITY)) ?
                       IDX_W'(tail_sum - SUM_W'(CAPACITY)) : IDX_W'(tail_sum);
    assign back_addr = (last_sum >= SUM_W'(CAPACITY)) ?
                       IDX_W'(last_sum - SUM_W'(CAPACITY)) : IDX_W'(last_sum);

    // command decode and next pointer state
    always_comb
    begin
        front_next = front_reg;
        occ_next   = occ_reg;
        err_next   = err_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_addr;
        if (ctrl.step)
        begin
            err_next = dq_pkg::ERR_NONE;
            unique case (ctrl.cmd)
                dq_pkg::CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        err_next = dq_pkg::ERR_PUSH_FULL;
                    end
                    else
                    begin
                        front_next = front_dec;
                        occ_next   = occ_reg + 1'b1;
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                    end
                end
                dq_pkg::CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        err_next = dq_pkg::ERR_PUSH_FULL;
                    end
                    else
                    begin
                        occ_next = occ_reg + 1'b1;
                        wr_en    = 1'b1;
                    end
                end
                dq_pkg::CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        err_next = dq_pkg::ERR_POP_EMPTY;
                    end
                    else
                    begin
                        front_next = front_inc;
                        occ_next   = occ_reg - 1'b1;
                    end
                end
                dq_pkg::CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        err_next = dq_pkg::ERR_POP_EMPTY;
                    end
                    else
                    begin
                        occ_next = occ_reg - 1'b1;
                    end
                end
                dq_pkg::CMD_CLEAR:
                begin
                    front_next = '0;
                    occ_next   = '0;
                end
                default:
                begin
                    // query and unused codes leave the front and occupancy alone; the error code is cleared above
                end
            endcase
        end
    end

    // pointer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            occ_reg   <= '0;
            err_reg   <= dq_pkg::ERR_NONE;
        end
        else
        begin
            front_reg <= front_next;
            occ_reg   <= occ_next;
            err_reg   <= err_next;
        end
    end

    assign front_addr      = front_reg;
    assign occupancy       = occ_reg;
    assign status.err      = err_reg;
    assign status.is_empty = empty;

endmodule

>>> hdl/double_ended_queue.sv
// double_ended_queue: bounded deque of signed values in a ring of two mirrored rams
// steps from input transfer to result: update/write, ram read, capture
// in_stall is raised outside the idle step, so a new command is taken only after the last result is captured
// a stalled result register holds the sequencer in its capture step until taken
// reset (rst_n, async active low) empties the queue; ram contents are not cleared
// depends on dq_pkg, dq_ram, dq_ptr
module double_ended_queue #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dq_pkg::CMD_W-1:0]            cmd,
    input  logic signed [dq_pkg::OUT_VALUE_W-1:0] push_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [dq_pkg::OUT_VALUE_W-1:0] front_value,
    output logic signed [dq_pkg::OUT_VALUE_W-1:0] back_value,
    output logic [dq_pkg::OUT_COUNT_W-1:0]      entry_count,
    output logic                                is_empty,
    output logic [dq_pkg::ERR_W-1:0]            error_code
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OVW   = dq_pkg::OUT_VALUE_W;

    dq_pkg::seq_state_t  state_reg, state_next;
    dq_pkg::ptr_ctrl_t   ptr_ctrl;
    dq_pkg::ptr_status_t ptr_status;

    logic                   in_accept, out_accept, rd_en, load;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr, front_addr, back_addr;
    logic [CNT_W-1:0]       occupancy;
    logic [VALUE_WIDTH-1:0] wr_data, front_rd, back_rd;
    logic [OVW-1:0]         front_ext, back_ext;

    logic                     out_valid_reg, out_valid_next;
    logic [OVW-1:0]           front_value_reg, back_value_reg;
    logic [dq_pkg::OUT_COUNT_W-1:0] entry_count_reg;
    logic                     is_empty_reg;
    logic [dq_pkg::ERR_W-1:0] error_code_reg;

    // handshakes
    assign in_stall   = (state_reg != dq_pkg::S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    // pointer unit
    assign ptr_ctrl.step = in_accept;
    assign ptr_ctrl.cmd  = cmd;

    dq_ptr #(
        .CAPACITY (CAPACITY)
    ) u_ptr (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ptr_ctrl),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .front_addr (front_addr),
        .back_addr  (back_addr),
        .occupancy  (occupancy),
        .status     (ptr_status)
    );

    // value width conversion on write and read
    generate
        if (VALUE_WIDTH >= OVW)
        begin : g_wide
            assign wr_data   = VALUE_WIDTH'($unsigned(push_value));
            assign front_ext = front_rd[OVW-1:0];
            assign back_ext  = back_rd[OVW-1:0];
        end
        else
        begin : g_narrow
            assign wr_data   = push_value[VALUE_WIDTH-1:0];
            assign front_ext = OVW'($signed(front_rd));
            assign back_ext  = OVW'($signed(back_rd));
        end
    endgenerate

    // mirrored rams, one read port for the front and one for the back
    assign rd_en = (state_reg == dq_pkg::S_READ);

    dq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram_front (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (front_addr),
        .rd_data (front_rd)
    );

    dq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram_back (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (back_addr),
        .rd_data (back_rd)
    );

    // sequencer: update, read, capture
    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        unique case (state_reg)
            dq_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = dq_pkg::S_READ;
                end
            end
            dq_pkg::S_READ:
            begin
                state_next = dq_pkg::S_DONE;
            end
            dq_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load       = 1'b1;
                    state_next = dq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, zero values when the queue is empty
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            front_value_reg <= ptr_status.is_empty ? '0 : front_ext;
            back_value_reg  <= ptr_status.is_empty ? '0 : back_ext;
            entry_count_reg <= dq_pkg::OUT_COUNT_W'(occupancy);
            is_empty_reg    <= ptr_status.is_empty;
            error_code_reg  <= ptr_status.err;
        end
    end

    assign out_valid   = out_valid_reg;
    assign front_value = front_value_reg;
    assign back_value  = back_value_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;
    assign error_code  = error_code_reg;

    // checks
    a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == dq_pkg::S_READ))
        else $error("transfer not followed by ram read");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= CNT_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && occupancy == '0 &&
         (cmd == dq_pkg::CMD_POP_FRONT || cmd == dq_pkg::CMD_POP_BACK))
        |=> (ptr_status.err == dq_pkg::ERR_POP_EMPTY && occupancy == '0))
        else $error("pop on empty queue not flagged");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == dq_pkg::S_DONE))
        else $error("result raised outside capture step");

endmodule
